FILE: sv/tcon_pkg.sv
`default_nettype none
package tcon_pkg;

  // Screen geometry
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;

  // Fixed field widths
  localparam int CUR_W    = 11;
  localparam int IDX_W    = 11;
  localparam int CHAR_W   = 8;
  localparam int CELL_W   = 16;
  localparam int COLOR_W  = 4;
  localparam int KIND_W   = 3;
  localparam int CFG_IDX_W = 1;

  // Derived widths
  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int COL_W  = $clog2(COLUMNS);

  // Cell constants
  localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;
  localparam logic [CELL_W-1:0] RESET_CELL = 16'h0720;
  localparam logic [COLOR_W-1:0] FG_RESET  = 4'h7;
  localparam logic [COLOR_W-1:0] BG_RESET  = 4'h0;

  typedef enum logic [KIND_W-1:0] {
    KIND_WRITE     = 3'd0,
    KIND_NEWLINE   = 3'd1,
    KIND_BACKSPACE = 3'd2,
    KIND_CLEAR     = 3'd3,
    KIND_READ      = 3'd4
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FG_COLOR = 1'b0,
    REG_BG_COLOR = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_COPY,
    ST_DRAIN,
    ST_FILL,
    ST_FINISH
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;
    logic set_ovf;
    logic do_write;
    logic do_back;
    logic do_newline;
    logic cur_home;
    logic cur_last_row;
    logic sweep_init;
    logic sweep_inc;
    logic copy_step;
    logic fill_we;
    logic fill_reset;
    logic result;
    logic result_rd;
  } ctl_t;

  // Status from datapath to controller
  typedef struct packed {
    logic at_end;
    logic cur_zero;
    logic scroll_needed;
    logic sweep_last;
    logic copy_last;
  } sts_t;

endpackage
`default_nettype wire

FILE: sv/text_console_cursor_and_scroll_core.sv
`default_nettype none
// Text console core: an 80x25 store of 16-bit cells (background, foreground, character)
// and a cursor. After reset the block is busy while it writes a grey-on-black blank into
// every cell, one cell a cycle; configuration writes are taken meanwhile.
// A command is taken when start is high and busy is low. Write, backspace, newline that
// stays on screen, read and unknown kinds keep busy high for a single state (ST_READ for a
// read, else ST_FINISH); done pulses for one cycle in the cycle after that with cursor,
// cell_data and overflow, and the receiver must take it then. Clear sweeps the store once
// through its single write port. A newline past the bottom row moves 1920 cells one row up
// through the registered read port and blanks the last 80.
module text_console_cursor_and_scroll_core
  import tcon_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [KIND_W-1:0]    kind,
  input  wire logic [CHAR_W-1:0]    char_code,
  input  wire logic [IDX_W-1:0]     cell_index,
  output logic                      done,
  output logic [CUR_W-1:0]          cursor,
  output logic [CELL_W-1:0]         cell_data,
  output logic                      overflow,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [COLOR_W-1:0]   cfg_data
);

  ctl_t ctl;
  sts_t sts;

  tcon_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .kind  (kind),
    .sts   (sts),
    .ctl   (ctl),
    .busy  (busy)
  );

  tcon_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .sts        (sts),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .char_code  (char_code),
    .cell_index (cell_index),
    .done       (done),
    .cursor     (cursor),
    .cell_data  (cell_data),
    .overflow   (overflow)
  );

endmodule
`default_nettype wire

FILE: sv/tcon_ctrl.sv
`default_nettype none
module tcon_ctrl
  import tcon_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [KIND_W-1:0] kind,
  input  wire sts_t              sts,
  output ctl_t                   ctl,
  output logic                   busy
);

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    ctl        = '0;
    case (state)
      ST_INIT: begin
        ctl.fill_we    = 1'b1;
        ctl.fill_reset = 1'b1;
        ctl.sweep_inc  = 1'b1;
        if (sts.sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          ctl.accept = 1'b1;
          state_next = ST_FINISH;
          case (kind)
            KIND_WRITE: begin
              if (sts.at_end) begin
                ctl.set_ovf = 1'b1;
              end else begin
                ctl.do_write = 1'b1;
              end
            end
            KIND_NEWLINE: begin
              if (sts.scroll_needed) begin
                ctl.sweep_init   = 1'b1;
                ctl.cur_last_row = 1'b1;
                state_next       = ST_COPY;
              end else begin
                ctl.do_newline = 1'b1;
              end
            end
            KIND_BACKSPACE: begin
              if (!sts.cur_zero) begin
                ctl.do_back = 1'b1;
              end
            end
            KIND_CLEAR: begin
              ctl.sweep_init = 1'b1;
              ctl.cur_home   = 1'b1;
              state_next     = ST_FILL;
            end
            KIND_READ: begin
              state_next = ST_READ;
            end
            default: begin
              state_next = ST_FINISH;
            end
          endcase
        end
      end
      ST_READ: begin
        ctl.result    = 1'b1;
        ctl.result_rd = 1'b1;
        state_next    = ST_IDLE;
      end
      ST_COPY: begin
        ctl.copy_step = 1'b1;
        ctl.sweep_inc = 1'b1;
        if (sts.copy_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // let the last row move land before blanking
        state_next = ST_FILL;
      end
      ST_FILL: begin
        ctl.fill_we   = 1'b1;
        ctl.sweep_inc = 1'b1;
        if (sts.sweep_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        ctl.result = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule
`default_nettype wire

FILE: sv/tcon_dp.sv
`default_nettype none
module tcon_dp
  import tcon_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire ctl_t                 ctl,
  output sts_t                      sts,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [COLOR_W-1:0]   cfg_data,
  input  wire logic [CHAR_W-1:0]    char_code,
  input  wire logic [IDX_W-1:0]     cell_index,
  output logic                      done,
  output logic [CUR_W-1:0]          cursor,
  output logic [CELL_W-1:0]         cell_data,
  output logic                      overflow
);

  localparam logic [CUR_W-1:0]  CELL_COUNT_C = CUR_W'(CELL_COUNT);
  localparam logic [CUR_W-1:0]  COLUMNS_C    = CUR_W'(COLUMNS);
  localparam logic [CUR_W-1:0]  LAST_ROW_C   = CUR_W'(CELL_COUNT - COLUMNS);
  localparam logic [ADDR_W-1:0] COL_STEP_A   = ADDR_W'(COLUMNS);
  localparam logic [ADDR_W-1:0] SWEEP_LAST_A = ADDR_W'(CELL_COUNT - 1);
  localparam logic [ADDR_W-1:0] COPY_LAST_A  = ADDR_W'(CELL_COUNT - COLUMNS - 1);
  localparam logic [COL_W-1:0]  COL_LAST     = COL_W'(COLUMNS - 1);

  logic [CELL_W-1:0] mem [CELL_COUNT];

  logic [COLOR_W-1:0] fg_color;
  logic [COLOR_W-1:0] bg_color;
  logic [CUR_W-1:0]   cur_pos;
  logic [CUR_W-1:0]   row_start;
  logic [COL_W-1:0]   col;
  logic [ADDR_W-1:0]  sweep;
  logic               copy_pend;
  logic [ADDR_W-1:0]  copy_wa;
  logic               ovf_q;
  logic               idx_ok;
  logic [CELL_W-1:0]  rd_data;

  logic               mem_we;
  logic [ADDR_W-1:0]  mem_wa;
  logic [CELL_W-1:0]  mem_wd;
  logic [ADDR_W-1:0]  mem_ra;
  logic [CUR_W-1:0]   cur_dec;

  assign cur_dec = cur_pos - CUR_W'(1);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fg_color <= FG_RESET;
      bg_color <= BG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FG_COLOR: fg_color <= cfg_data;
        REG_BG_COLOR: bg_color <= cfg_data;
        default: ;
      endcase
    end
  end

  // Cursor, kept with its row start and column to avoid a divide
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_pos   <= '0;
      row_start <= '0;
      col       <= '0;
    end else if (ctl.cur_home) begin
      cur_pos   <= '0;
      row_start <= '0;
      col       <= '0;
    end else if (ctl.cur_last_row) begin
      cur_pos   <= LAST_ROW_C;
      row_start <= LAST_ROW_C;
      col       <= '0;
    end else if (ctl.do_newline) begin
      cur_pos   <= row_start + COLUMNS_C;
      row_start <= row_start + COLUMNS_C;
      col       <= '0;
    end else if (ctl.do_write) begin
      cur_pos <= cur_pos + CUR_W'(1);
      if (col == COL_LAST) begin
        col       <= '0;
        row_start <= row_start + COLUMNS_C;
      end else begin
        col <= col + COL_W'(1);
      end
    end else if (ctl.do_back) begin
      cur_pos <= cur_dec;
      if (col == '0) begin
        col       <= COL_LAST;
        row_start <= row_start - COLUMNS_C;
      end else begin
        col <= col - COL_W'(1);
      end
    end
  end

  // Sweep counter and delayed copy write
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep     <= '0;
      copy_pend <= 1'b0;
    end else begin
      if (ctl.sweep_init) begin
        sweep <= '0;
      end else if (ctl.sweep_inc) begin
        sweep <= (sweep == SWEEP_LAST_A) ? '0 : sweep + ADDR_W'(1);
      end
      copy_pend <= ctl.copy_step;
    end
  end

  always_ff @(posedge clk) begin
    copy_wa <= sweep;
  end

  // Per-item flags
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      ovf_q  <= ctl.set_ovf;
      idx_ok <= (cell_index < CELL_COUNT_C);
    end
  end

  // Write port select
  always_comb begin
    mem_we = 1'b0;
    mem_wa = sweep;
    mem_wd = {bg_color, fg_color, BLANK_CHAR};
    if (copy_pend) begin
      mem_we = 1'b1;
      mem_wa = copy_wa;
      mem_wd = rd_data;
    end else if (ctl.fill_we) begin
      mem_we = 1'b1;
      mem_wa = sweep;
      mem_wd = ctl.fill_reset ? RESET_CELL : {bg_color, fg_color, BLANK_CHAR};
    end else if (ctl.do_write) begin
      mem_we = 1'b1;
      mem_wa = cur_pos[ADDR_W-1:0];
      mem_wd = {bg_color, fg_color, char_code};
    end else if (ctl.do_back) begin
      mem_we = 1'b1;
      mem_wa = cur_dec[ADDR_W-1:0];
      mem_wd = {bg_color, fg_color, BLANK_CHAR};
    end
  end

  assign mem_ra = ctl.copy_step ? (sweep + COL_STEP_A) : cell_index[ADDR_W-1:0];

  // Cell store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[mem_ra];
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.result;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.result) begin
      cursor    <= cur_pos;
      cell_data <= (ctl.result_rd && idx_ok) ? rd_data : '0;
      overflow  <= ctl.result_rd ? 1'b0 : ovf_q;
    end
  end

  // Status
  assign sts.at_end        = (cur_pos == CELL_COUNT_C);
  assign sts.cur_zero      = (cur_pos == '0);
  assign sts.scroll_needed = (row_start >= LAST_ROW_C);
  assign sts.sweep_last    = (sweep == SWEEP_LAST_A);
  assign sts.copy_last     = (sweep == COPY_LAST_A);

  // Checks
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    cur_pos <= CELL_COUNT_C)
    else $error("cursor beyond screen");

  a_cursor_split: assert property (@(posedge clk) disable iff (rst)
    cur_pos == row_start + CUR_W'(col))
    else $error("cursor out of step with row start and column");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for two cycles");

  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    !(copy_pend && (ctl.fill_we || ctl.do_write || ctl.do_back)))
    else $error("row move write collides with another write");

endmodule
`default_nettype wire

FILE: bench/text_console_cursor_and_scroll_core_test.sv
`timescale 1ns / 1ps
module text_console_cursor_and_scroll_core_test;
  import tcon_pkg::*;

  // Command codes the package leaves unnamed: the block must ignore them
  localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;

  localparam int MAX_REPORTS   = 10;
  localparam int DRAIN_CYCLES  = 2100;
  localparam int RANDOM_ITEMS  = 40;
  localparam int MAX_IDX_VALUE = (1 << IDX_W) - 1;

  typedef struct {
    logic [CUR_W-1:0]  cursor;
    logic [CELL_W-1:0] data;
    logic              ovf;
  } console_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic [KIND_W-1:0]    kind = '0;
  logic [CHAR_W-1:0]    char_code = '0;
  logic [IDX_W-1:0]     cell_index = '0;
  logic                 done;
  logic [CUR_W-1:0]     cursor;
  logic [CELL_W-1:0]    cell_data;
  logic                 overflow;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COLOR_W-1:0]   cfg_data = '0;

  // Shadow copy of the console: cell store, cursor and colors
  logic [CELL_W-1:0]  screen_model [CELL_COUNT];
  int unsigned        cursor_model;
  logic [COLOR_W-1:0] fg_model;
  logic [COLOR_W-1:0] bg_model;

  console_result_t expected_results[$];
  int unsigned     mismatch_count = 0;
  bit              steady_sender = 1'b0;

  text_console_cursor_and_scroll_core uut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .kind       (kind),
    .char_code  (char_code),
    .cell_index (cell_index),
    .done       (done),
    .cursor     (cursor),
    .cell_data  (cell_data),
    .overflow   (overflow),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #30_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic logic [CELL_W-1:0] blank_cell();
    return {bg_model, fg_model, BLANK_CHAR};
  endfunction

  // Apply one command to the shadow console and return the result it yields
  task automatic predict_console(input logic [KIND_W-1:0] k, input logic [CHAR_W-1:0] ch,
                                 input logic [IDX_W-1:0] idx, output console_result_t res);
    int unsigned nxt;
    res.data = '0;
    res.ovf  = 1'b0;
    case (k)
      KIND_WRITE: begin
        if (cursor_model < CELL_COUNT) begin
          screen_model[cursor_model] = {bg_model, fg_model, ch};
          cursor_model++;
        end else begin
          res.ovf = 1'b1;
        end
      end
      KIND_NEWLINE: begin
        nxt = (cursor_model / COLUMNS + 1) * COLUMNS;
        if (nxt >= CELL_COUNT) begin
          // scroll up one row and blank the bottom row
          for (int i = 0; i + COLUMNS < CELL_COUNT; i++)
            screen_model[i] = screen_model[i + COLUMNS];
          for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
            screen_model[i] = blank_cell();
          nxt = CELL_COUNT - COLUMNS;
        end
        cursor_model = nxt;
      end
      KIND_BACKSPACE: begin
        if (cursor_model > 0) begin
          cursor_model--;
          screen_model[cursor_model] = blank_cell();
        end
      end
      KIND_CLEAR: begin
        for (int i = 0; i < CELL_COUNT; i++)
          screen_model[i] = blank_cell();
        cursor_model = 0;
      end
      KIND_READ: begin
        if (idx < CELL_COUNT)
          res.data = screen_model[idx];
      end
      default: begin
      end
    endcase
    res.cursor = cursor_model[CUR_W-1:0];
  endtask

  // Mostly short gaps, now and then a long one, none in steady stretches
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady_sender)
      return 0;
    r = $urandom_range(0, 19);
    if (r < 12)
      return 0;
    if (r < 18)
      return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Offer one item, hold it until taken, then record its expected result
  task automatic send_command(input logic [KIND_W-1:0] k, input logic [CHAR_W-1:0] ch,
                              input logic [IDX_W-1:0] idx);
    console_result_t want;
    int unsigned     gap;
    start      <= 1'b1;
    kind       <= k;
    char_code  <= ch;
    cell_index <= idx;
    do @(posedge clk); while (busy !== 1'b0);
    predict_console(k, ch, idx, want);
    expected_results.push_back(want);
    gap = pick_gap();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop start and hold off until every expected result has arrived
  task automatic wait_until_drained();
    start <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write both color registers while the block is idle
  task automatic write_colors(input logic [COLOR_W-1:0] fg, input logic [COLOR_W-1:0] bg);
    wait_until_drained();
    cfg_we    <= 1'b1;
    cfg_index <= REG_FG_COLOR;
    cfg_data  <= fg;
    @(posedge clk);
    fg_model  = fg;
    cfg_index <= REG_BG_COLOR;
    cfg_data  <= bg;
    @(posedge clk);
    bg_model  = bg;
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_random_write();
    send_command(KIND_WRITE, CHAR_W'($urandom_range(0, 255)),
                 IDX_W'($urandom_range(0, MAX_IDX_VALUE)));
  endtask

  task automatic send_read(input int unsigned idx);
    send_command(KIND_READ, CHAR_W'($urandom_range(0, 255)), IDX_W'(idx));
  endtask

  task automatic report_mismatch(input string what, input console_result_t want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t: %s: expected cursor %0d data %h ovf %b, got cursor %0d data %h ovf %b",
               $realtime, what, want.cursor, want.data, want.ovf, cursor, cell_data, overflow);
  endtask

  // Compare every result with the oldest expectation
  always @(posedge clk) begin : check_results
    console_result_t want;
    if (!rst && done === 1'b1) begin
      if (expected_results.size() == 0) begin
        want = '{default: '0};
        report_mismatch("result with no item pending", want);
      end else begin
        want = expected_results.pop_front();
        if (cursor !== want.cursor || cell_data !== want.data || overflow !== want.ovf)
          report_mismatch("result mismatch", want);
      end
    end
  end

  // Cells after the power-up pass, including out-of-range reads
  task automatic test_power_up();
    send_read(0);
    send_read(CELL_COUNT - 1);
    send_read(CELL_COUNT);
    send_read(MAX_IDX_VALUE);
    send_command(KIND_BACKSPACE, 8'hFF, '1);
  endtask

  // Character extremes, backspace at and above zero, newline within the screen
  task automatic test_edit_keys();
    send_command(KIND_WRITE, 8'h00, '1);
    send_command(KIND_WRITE, 8'hFF, '0);
    send_command(KIND_WRITE, 8'h80, '1);
    send_command(KIND_WRITE, 8'h7F, '0);
    for (int i = 0; i < 5; i++)
      send_read(i);
    send_command(KIND_BACKSPACE, 8'h00, '0);
    send_read(3);
    send_command(KIND_NEWLINE, 8'hAA, 11'h555);
    send_command(KIND_WRITE, 8'h41, '0);
    send_read(COLUMNS);
    for (int i = 0; i < COLUMNS + 3; i++)
      send_command(KIND_BACKSPACE, 8'h00, '0);
    send_read(0);
  endtask

  // Spare command codes must leave everything alone
  task automatic test_spare_kinds();
    for (int k = KIND_SPARE_FIRST; k <= KIND_SPARE_LAST; k++)
      send_command(KIND_W'(k), CHAR_W'($urandom_range(0, 255)),
                   IDX_W'($urandom_range(0, MAX_IDX_VALUE)));
    send_read(0);
  endtask

  // Color extremes on writes, backspace blanks and clear fill
  task automatic test_colors();
    write_colors('1, '1);
    send_command(KIND_WRITE, 8'h5A, '0);
    send_command(KIND_WRITE, 8'hA5, '0);
    send_command(KIND_BACKSPACE, 8'h00, '0);
    send_read(0);
    send_read(1);
    write_colors('0, '1);
    send_command(KIND_CLEAR, 8'h00, '0);
    send_read(CELL_COUNT - 1);
    write_colors('1, '0);
    send_command(KIND_WRITE, 8'h33, '0);
    send_read(0);
  endtask

  // Walk to the bottom row, fill it, overflow, then scroll from the end
  task automatic test_end_of_screen();
    send_command(KIND_CLEAR, 8'h00, '0);
    for (int i = 0; i < ROWS - 1; i++)
      send_command(KIND_NEWLINE, 8'h00, '0);
    for (int i = 0; i < COLUMNS; i++)
      send_random_write();
    send_random_write();
    send_random_write();
    send_read(CELL_COUNT - 1);
    send_command(KIND_NEWLINE, 8'h00, '0);
    send_read(CELL_COUNT - COLUMNS - 1);
    send_read(CELL_COUNT - COLUMNS);
    send_read(CELL_COUNT - 1);
    for (int i = 0; i < COLUMNS; i++)
      send_random_write();
    send_command(KIND_BACKSPACE, 8'h00, '0);
    send_read(CELL_COUNT - 1);
    send_random_write();
    send_random_write();
    // newline from mid bottom row scrolls as well
    send_command(KIND_BACKSPACE, 8'h00, '0);
    send_command(KIND_NEWLINE, 8'h00, '0);
    send_command(KIND_WRITE, 8'h21, '0);
    send_command(KIND_NEWLINE, 8'h00, '0);
    send_read(CELL_COUNT - 2 * COLUMNS);
  endtask

  function automatic logic [COLOR_W-1:0] pick_color();
    int unsigned r;
    r = $urandom_range(0, 3);
    if (r == 0)
      return '0;
    if (r == 1)
      return '1;
    return COLOR_W'($urandom_range(0, 15));
  endfunction

  // Random bursts: write runs that reach the screen end, edits, reads, noise
  task automatic test_random();
    int unsigned sent;
    int unsigned pick;
    int unsigned len;
    int unsigned w;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      steady_sender = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 19);
      if (pick < 8) begin
        w = $urandom_range(0, 99);
        if (w < 40)
          send_random_write();
        else if (w < 55)
          send_command(KIND_NEWLINE, CHAR_W'($urandom), IDX_W'($urandom));
        else if (w < 72)
          send_command(KIND_BACKSPACE, CHAR_W'($urandom), IDX_W'($urandom));
        else if (w < 76)
          send_command(KIND_CLEAR, CHAR_W'($urandom), IDX_W'($urandom));
        else if (w < 94)
          send_read($urandom_range(0, MAX_IDX_VALUE));
        else
          send_command(KIND_W'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST)),
                       CHAR_W'($urandom), IDX_W'($urandom));
        sent++;
      end else if (pick < 12) begin
        len = $urandom_range(1, COLUMNS + 20);
        for (int i = 0; i < len; i++)
          send_random_write();
        sent += len;
      end else if (pick < 15) begin
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 3) == 0)
            send_read($urandom_range(CELL_COUNT, MAX_IDX_VALUE));
          else if (cursor_model > 0 && $urandom_range(0, 1) == 0)
            send_read(cursor_model - 1);
          else
            send_read($urandom_range(0, CELL_COUNT - 1));
        end
        sent += len;
      end else if (pick < 17) begin
        len = $urandom_range(1, 10);
        for (int i = 0; i < len; i++)
          send_command(KIND_BACKSPACE, CHAR_W'($urandom), IDX_W'($urandom));
        sent += len;
      end else if (pick < 19) begin
        len = $urandom_range(1, 4);
        for (int i = 0; i < len; i++)
          send_command(KIND_NEWLINE, CHAR_W'($urandom), IDX_W'($urandom));
        sent += len;
      end else begin
        write_colors(pick_color(), pick_color());
      end
    end
    steady_sender = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < CELL_COUNT; i++)
      screen_model[i] = RESET_CELL;
    cursor_model = 0;
    fg_model     = FG_RESET;
    bg_model     = BG_RESET;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_power_up();
    test_edit_keys();
    test_spare_kinds();
    test_colors();
    test_end_of_screen();
    wait_until_drained();
    test_random();

    // Drain and watch for stray results
    wait_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

FILE: text_console_cursor_and_scroll_core.f
sv/tcon_pkg.sv
sv/tcon_ctrl.sv
sv/tcon_dp.sv
sv/text_console_cursor_and_scroll_core.sv
bench/text_console_cursor_and_scroll_core_test.sv
